/* hw/rtl/tcp_connection_table_engine_defines.svh */
// assertion macros for the connection table engine
`ifndef TCP_CONNECTION_TABLE_ENGINE_DEFINES_SVH
`define TCP_CONNECTION_TABLE_ENGINE_DEFINES_SVH

// clocked check, idle while reset is low
`define TCTE_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcte assertion failed");

// clocked check that also holds during reset
`define TCTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tcte assertion failed");

`endif

/* hw/rtl/tcte_pkg.sv */
package tcte_pkg;

  localparam int unsigned SOCKETS_DEF = 8;
  localparam int unsigned MAX_RES     = 8;
  localparam int unsigned APB_AW      = 4;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [7:0]  CNT8_MAX  = 8'hFF;

  localparam logic [15:0] RESEND_RST = 16'd16;
  localparam logic [7:0]  RETRY_RST  = 8'd5;
  localparam logic        SERVER_RST = 1'b1;
  localparam logic [31:0] ISEQ_RST   = 32'hAAAAAAAA;

  typedef enum logic [1:0] {
    REG_RESEND = 2'd0,
    REG_RETRY  = 2'd1,
    REG_SERVER = 2'd2,
    REG_ISEQ   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_SEG   = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_SEND  = 2'd2,
    REQ_CLOSE = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [15:0] resend_ticks;
    logic [7:0]  max_retries;
    logic        server_enabled;
    logic [31:0] initial_seq;
  } cfg_t;

  typedef struct packed {
    req_type_e   op;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [7:0]  flags_in;
    logic [10:0] payload_len;
    logic        syn_accepted;
    logic        ack_now;
    logic [2:0]  slot_sel;
  } item_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [31:0] remote_addr;
    logic [31:0] seq;
    logic [31:0] next_seq;
    logic [31:0] ack;
    logic [7:0]  send_flags;
    logic [15:0] since_sent;
    logic [15:0] idle;
    logic [7:0]  retries;
  } rec_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic [7:0]  flags_out;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic        is_resend;
    logic        closing;
    logic        last;
  } rsp_t;

endpackage

/* hw/rtl/tcte_if.sv */
interface tcte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] remote_addr;
  logic [15:0] remote_port;
  logic [15:0] local_port;
  logic [31:0] seq_in;
  logic [31:0] ack_in;
  logic [7:0]  flags_in;
  logic [10:0] payload_len;
  logic        syn_accepted;
  logic        ack_now;
  logic [2:0]  slot_sel;

  modport source (
    output valid, req_type, remote_addr, remote_port, local_port, seq_in, ack_in,
           flags_in, payload_len, syn_accepted, ack_now, slot_sel,
    input  ready
  );
  modport sink (
    input  valid, req_type, remote_addr, remote_port, local_port, seq_in, ack_in,
           flags_in, payload_len, syn_accepted, ack_now, slot_sel,
    output ready
  );
endinterface

interface tcte_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slot;
  logic [7:0]  flags_out;
  logic [31:0] seq_out;
  logic [31:0] ack_out;
  logic [31:0] peer_addr;
  logic [15:0] peer_port;
  logic [15:0] own_port;
  logic        is_resend;
  logic        closing;
  logic        last;

  modport source (
    output valid, slot, flags_out, seq_out, ack_out, peer_addr, peer_port, own_port,
           is_resend, closing, last,
    input  ready
  );
  modport sink (
    input  valid, slot, flags_out, seq_out, ack_out, peer_addr, peer_port, own_port,
           is_resend, closing, last,
    output ready
  );
endinterface

/* hw/rtl/tcte_regs.sv */
module tcte_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tcte_pkg::APB_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tcte_pkg::cfg_t                   cfg_o
);

  tcte_pkg::cfg_t     cfg_q, cfg_d;
  tcte_pkg::reg_idx_e sel;
  logic               wr;

  assign sel    = tcte_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (sel)
        tcte_pkg::REG_RESEND: cfg_d.resend_ticks   = pwdata[15:0];
        tcte_pkg::REG_RETRY:  cfg_d.max_retries    = pwdata[7:0];
        tcte_pkg::REG_SERVER: cfg_d.server_enabled = pwdata[0];
        tcte_pkg::REG_ISEQ:   cfg_d.initial_seq    = pwdata;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      tcte_pkg::REG_RESEND: prdata = {16'd0, cfg_q.resend_ticks};
      tcte_pkg::REG_RETRY:  prdata = {24'd0, cfg_q.max_retries};
      tcte_pkg::REG_SERVER: prdata = {31'd0, cfg_q.server_enabled};
      tcte_pkg::REG_ISEQ:   prdata = cfg_q.initial_seq;
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resend_ticks   <= tcte_pkg::RESEND_RST;
      cfg_q.max_retries    <= tcte_pkg::RETRY_RST;
      cfg_q.server_enabled <= tcte_pkg::SERVER_RST;
      cfg_q.initial_seq    <= tcte_pkg::ISEQ_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hw/rtl/tcte_front.sv */
module tcte_front #(
  parameter int unsigned SOCKETS = tcte_pkg::SOCKETS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tcte_req_if.sink        req_i,
  output tcte_pkg::item_t item_o,
  output logic            item_valid_o,
  input  logic            item_pop_i
);

  tcte_pkg::item_t q_mem [2];
  tcte_pkg::item_t in_item;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            accept, keep, push, sel_ok;

  assign in_item.op           = tcte_pkg::req_type_e'(req_i.req_type);
  assign in_item.remote_addr  = req_i.remote_addr;
  assign in_item.remote_port  = req_i.remote_port;
  assign in_item.local_port   = req_i.local_port;
  assign in_item.seq_in       = req_i.seq_in;
  assign in_item.ack_in       = req_i.ack_in;
  assign in_item.flags_in     = req_i.flags_in;
  assign in_item.payload_len  = req_i.payload_len;
  assign in_item.syn_accepted = req_i.syn_accepted;
  assign in_item.ack_now      = req_i.ack_now;
  assign in_item.slot_sel     = req_i.slot_sel;

  // send and close name a slot; slot 0 and slots past the table are dropped here
  assign sel_ok = (req_i.slot_sel != 3'd0) && (int'(req_i.slot_sel) < SOCKETS);

  always_comb begin
    case (in_item.op)
      tcte_pkg::REQ_SEG,
      tcte_pkg::REQ_TICK: keep = 1'b1;
      default:            keep = sel_ok;
    endcase
  end

  assign req_i.ready  = (cnt_q != 2'd2);
  assign accept       = req_i.valid && req_i.ready;
  assign push         = accept && keep;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

endmodule

/* hw/rtl/tcte_back.sv */
module tcte_back #(
  parameter int unsigned SOCKETS = tcte_pkg::SOCKETS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcte_pkg::cfg_t  cfg_i,
  input  tcte_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  output tcte_pkg::rsp_t  rsp_data_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i
);

  localparam int unsigned SW = $clog2(SOCKETS);
  localparam logic [SW-1:0] LAST_IDX  = SW'(SOCKETS - 1);
  localparam logic [SW-1:0] FIRST_IDX = SW'(1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SRD  = 9'b000000010,
    ST_SEV  = 9'b000000100,
    ST_SACT = 9'b000001000,
    ST_TRD  = 9'b000010000,
    ST_TEV  = 9'b000100000,
    ST_TFIN = 9'b001000000,
    ST_XRD  = 9'b010000000,
    ST_XEV  = 9'b100000000
  } bst_e;

  function automatic tcte_pkg::rsp_t slot_rsp(logic [2:0] sl, tcte_pkg::rec_t r,
                                              logic rs, logic cl);
    tcte_pkg::rsp_t o;
    o.slot      = sl;
    o.flags_out = r.send_flags;
    o.seq_out   = r.seq;
    o.ack_out   = r.ack;
    o.peer_addr = r.remote_addr;
    o.peer_port = r.remote_port;
    o.own_port  = r.local_port;
    o.is_resend = rs;
    o.closing   = cl;
    o.last      = 1'b1;
    return o;
  endfunction

  // arms the resend timer when the sent flags carry data, SYN or FIN
  function automatic tcte_pkg::rec_t after_send(tcte_pkg::rec_t r, logic [10:0] plen);
    tcte_pkg::rec_t o;
    o = r;
    if ((r.send_flags & (tcte_pkg::FL_PSH | tcte_pkg::FL_SYN | tcte_pkg::FL_FIN)) != 8'd0)
    begin
      o.since_sent = 16'd1;
      o.retries    = 8'd0;
      if (plen == 11'd0) begin
        o.next_seq = r.seq + 32'd1;
      end else begin
        o.next_seq = r.next_seq + {21'd0, plen};
      end
    end
    return o;
  endfunction

  bst_e            st_q, st_d;
  logic [SW-1:0]   idx_q, idx_d;
  tcte_pkg::item_t it_q, it_d;
  logic [SOCKETS-1:0] open_q;
  logic            found_q, found_d, free_v_q, free_v_d;
  logic [SW-1:0]   hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  tcte_pkg::rec_t  hit_q, hit_d;
  logic [3:0]      res_cnt_q, res_cnt_d;
  tcte_pkg::rsp_t  hold_q, hold_d, out_q, emit_r;
  logic            hold_v_q, hold_v_d, out_v_q, emit_v, out_free;
  logic            open_set, open_clr;
  logic [SW-1:0]   open_idx;

  tcte_pkg::rec_t  tbl_mem [SOCKETS];
  tcte_pkg::rec_t  rd_q, wr_rec;
  logic            mem_we;
  logic [SW-1:0]   mem_waddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= wr_rec;
    end
    rd_q <= tbl_mem[idx_q];
  end

  assign out_free    = !out_v_q || rsp_ready_i;
  assign rsp_data_o  = out_q;
  assign rsp_valid_o = out_v_q;

  always_comb begin
    tcte_pkg::rec_t m;
    tcte_pkg::rec_t nr;
    tcte_pkg::rsp_t ar;
    logic           a_emit, a_we, a_set, a_clr, hit, syn_path, fire, cl;
    logic [SW-1:0]  a_idx;
    logic [15:0]    since_n;

    st_d       = st_q;
    idx_d      = idx_q;
    it_d       = it_q;
    found_d    = found_q;
    free_v_d   = free_v_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    hit_d      = hit_q;
    res_cnt_d  = res_cnt_q;
    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    item_pop_o = 1'b0;
    emit_v     = 1'b0;
    emit_r     = hold_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    wr_rec     = rd_q;
    open_set   = 1'b0;
    open_clr   = 1'b0;
    open_idx   = idx_q;
    m          = hit_q;
    nr         = rd_q;
    ar         = hold_q;
    a_emit     = 1'b0;
    a_we       = 1'b0;
    a_set      = 1'b0;
    a_clr      = 1'b0;
    a_idx      = hit_idx_q;
    hit        = 1'b0;
    syn_path   = 1'b0;
    fire       = 1'b0;
    cl         = 1'b0;
    since_n    = 16'd0;

    case (st_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          it_d       = item_i;
          found_d    = 1'b0;
          free_v_d   = 1'b0;
          res_cnt_d  = 4'd0;
          case (item_i.op)
            tcte_pkg::REQ_SEG: begin
              idx_d = FIRST_IDX;
              st_d  = ST_SRD;
            end
            tcte_pkg::REQ_TICK: begin
              idx_d = FIRST_IDX;
              st_d  = ST_TRD;
            end
            default: begin
              idx_d = SW'(item_i.slot_sel);
              st_d  = ST_XRD;
            end
          endcase
        end
      end

      ST_SRD: st_d = ST_SEV;

      ST_SEV: begin
        hit = open_q[idx_q] && (rd_q.local_port == it_q.local_port) &&
              (rd_q.remote_port == it_q.remote_port) &&
              (rd_q.remote_addr == it_q.remote_addr);
        if (hit && !found_q) begin
          found_d   = 1'b1;
          hit_idx_d = idx_q;
          hit_d     = rd_q;
        end
        if (!open_q[idx_q] && !free_v_q) begin
          free_v_d   = 1'b1;
          free_idx_d = idx_q;
        end
        if (idx_q == LAST_IDX) begin
          st_d = ST_SACT;
        end else begin
          idx_d = idx_q + FIRST_IDX;
          st_d  = ST_SRD;
        end
      end

      ST_SACT: begin
        syn_path = cfg_i.server_enabled && ((it_q.flags_in & tcte_pkg::FL_SYN) != 8'd0);
        if (syn_path && it_q.syn_accepted && free_v_q) begin
          // new passive open
          nr.local_port  = it_q.local_port;
          nr.remote_port = it_q.remote_port;
          nr.remote_addr = it_q.remote_addr;
          nr.ack         = it_q.seq_in + 32'd1;
          nr.seq         = cfg_i.initial_seq;
          nr.send_flags  = tcte_pkg::FL_SYN | tcte_pkg::FL_ACK;
          nr.idle        = 16'd0;
          ar             = slot_rsp(3'(free_idx_q), nr, 1'b0, 1'b0);
          nr.seq         = cfg_i.initial_seq + 32'd1;
          nr.next_seq    = cfg_i.initial_seq + 32'd1;
          nr.since_sent  = 16'd1;
          nr.retries     = 8'd0;
          a_idx          = free_idx_q;
          a_we           = 1'b1;
          a_set          = 1'b1;
          a_emit         = 1'b1;
        end else if (syn_path || !found_q) begin
          // stateless reset
          ar.slot      = 3'd0;
          ar.flags_out = tcte_pkg::FL_RST;
          ar.seq_out   = ((it_q.flags_in & tcte_pkg::FL_ACK) != 8'd0) ? it_q.ack_in : 32'd0;
          ar.ack_out   = 32'd0;
          ar.peer_addr = it_q.remote_addr;
          ar.peer_port = it_q.remote_port;
          ar.own_port  = it_q.local_port;
          ar.is_resend = 1'b0;
          ar.closing   = 1'b0;
          ar.last      = 1'b1;
          a_emit       = 1'b1;
        end else if ((it_q.flags_in & tcte_pkg::FL_RST) != 8'd0) begin
          nr            = m;
          nr.send_flags = tcte_pkg::FL_RST | tcte_pkg::FL_ACK;
          ar            = slot_rsp(3'(hit_idx_q), nr, 1'b0, 1'b1);
          a_we          = 1'b1;
          a_clr         = 1'b1;
          a_emit        = 1'b1;
        end else begin
          if (((it_q.flags_in & tcte_pkg::FL_ACK) != 8'd0) && (it_q.ack_in == m.next_seq))
          begin
            m.idle       = 16'd0;
            m.since_sent = 16'd0;
            m.seq        = m.next_seq;
          end
          nr   = m;
          a_we = 1'b1;
          if ((it_q.flags_in & tcte_pkg::FL_FIN) != 8'd0) begin
            nr.ack        = m.ack + 32'd1;
            nr.send_flags = tcte_pkg::FL_ACK | tcte_pkg::FL_FIN;
            ar            = slot_rsp(3'(hit_idx_q), nr, 1'b0, 1'b1);
            nr            = after_send(nr, 11'd0);
            a_clr         = 1'b1;
            a_emit        = 1'b1;
          end else if ((it_q.payload_len != 11'd0) && (m.ack == it_q.seq_in)) begin
            // in-order data
            nr.ack = it_q.seq_in + {21'd0, it_q.payload_len};
            if (it_q.ack_now) begin
              a_emit = 1'b1;
              if (m.since_sent != 16'd0) begin
                // frame still unacknowledged: bare ack on slot 0 keeps it
                ar.slot      = 3'd0;
                ar.flags_out = tcte_pkg::FL_ACK;
                ar.seq_out   = m.next_seq;
                ar.ack_out   = nr.ack;
                ar.peer_addr = it_q.remote_addr;
                ar.peer_port = it_q.remote_port;
                ar.own_port  = it_q.local_port;
                ar.is_resend = 1'b0;
                ar.closing   = 1'b0;
                ar.last      = 1'b1;
              end else begin
                nr.send_flags = tcte_pkg::FL_ACK;
                ar            = slot_rsp(3'(hit_idx_q), nr, 1'b0, 1'b0);
              end
            end
          end
        end
        if (!a_emit || out_free) begin
          mem_we    = a_we;
          mem_waddr = a_idx;
          wr_rec    = nr;
          open_set  = a_set;
          open_clr  = a_clr;
          open_idx  = a_idx;
          emit_v    = a_emit;
          emit_r    = ar;
          st_d      = ST_IDLE;
        end
      end

      ST_TRD: st_d = ST_TEV;

      ST_TEV: begin
        nr = rd_q;
        if (open_q[idx_q]) begin
          if (rd_q.idle != tcte_pkg::CNT16_MAX) begin
            nr.idle = rd_q.idle + 16'd1;
          end
          if (rd_q.since_sent != 16'd0) begin
            since_n = (rd_q.since_sent != tcte_pkg::CNT16_MAX) ?
                      rd_q.since_sent + 16'd1 : rd_q.since_sent;
            nr.since_sent = since_n;
            fire = (since_n > cfg_i.resend_ticks) && (res_cnt_q < 4'(tcte_pkg::MAX_RES));
            if (fire) begin
              nr.since_sent = 16'd1;
              if (rd_q.retries != tcte_pkg::CNT8_MAX) begin
                nr.retries = rd_q.retries + 8'd1;
              end
              cl = rd_q.retries > cfg_i.max_retries;
            end
          end
        end
        if (!(fire && hold_v_q && !out_free)) begin
          mem_we = open_q[idx_q];
          wr_rec = nr;
          if (fire) begin
            // previous retransmit goes out, this one waits to learn if it is last
            emit_v      = hold_v_q;
            emit_r      = hold_q;
            emit_r.last = 1'b0;
            hold_d      = slot_rsp(3'(idx_q), rd_q, 1'b1, cl);
            hold_v_d    = 1'b1;
            res_cnt_d   = res_cnt_q + 4'd1;
            open_clr    = cl;
          end
          if (idx_q == LAST_IDX) begin
            st_d = ST_TFIN;
          end else begin
            idx_d = idx_q + FIRST_IDX;
            st_d  = ST_TRD;
          end
        end
      end

      ST_TFIN: begin
        if (!hold_v_q) begin
          st_d = ST_IDLE;
        end else if (out_free) begin
          emit_v      = 1'b1;
          emit_r      = hold_q;
          emit_r.last = 1'b1;
          hold_v_d    = 1'b0;
          st_d        = ST_IDLE;
        end
      end

      ST_XRD: st_d = ST_XEV;

      ST_XEV: begin
        if (!open_q[idx_q]) begin
          st_d = ST_IDLE;
        end else begin
          nr = rd_q;
          if (it_q.op == tcte_pkg::REQ_SEND) begin
            nr.send_flags = it_q.flags_in;
            ar            = slot_rsp(3'(idx_q), nr, 1'b0, 1'b0);
            nr            = after_send(nr, it_q.payload_len);
          end else begin
            nr.send_flags = tcte_pkg::FL_FIN;
            ar            = slot_rsp(3'(idx_q), nr, 1'b0, 1'b0);
            nr            = after_send(nr, 11'd0);
          end
          if (out_free) begin
            mem_we = 1'b1;
            wr_rec = nr;
            emit_v = 1'b1;
            emit_r = ar;
            st_d   = ST_IDLE;
          end
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q       <= it_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hit_q      <= hit_d;
    hold_q     <= hold_d;
    if (emit_v) begin
      out_q <= emit_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      idx_q     <= '0;
      open_q    <= '0;
      found_q   <= 1'b0;
      free_v_q  <= 1'b0;
      res_cnt_q <= 4'd0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
      free_v_q  <= free_v_d;
      res_cnt_q <= res_cnt_d;
      hold_v_q  <= hold_v_d;
      if (open_set) begin
        open_q[open_idx] <= 1'b1;
      end else if (open_clr) begin
        open_q[open_idx] <= 1'b0;
      end
      if (emit_v) begin
        out_v_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/tcp_connection_table_engine.sv */
// a segment or a tick walks slots 1 to SOCKETS-1, reading and then evaluating each slot;
// send and close read only the named slot; the engine handles one request at a time
// while the front queue holds up to two more, and a stalled result port holds the engine
// reset: async active low; all slots closed, registers at their defaults, queue empty
module tcp_connection_table_engine #(
  parameter int unsigned SOCKETS = tcte_pkg::SOCKETS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tcte_req_if.sink                    req_i,
  tcte_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcte_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // configuration registers
  tcte_pkg::cfg_t  cfg;

  // queued request between front and engine
  tcte_pkg::item_t item;
  logic            item_valid, item_pop;

  // engine result register
  tcte_pkg::rsp_t  rsp;

  tcte_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: takes requests, decodes the kind, drops send/close on slots
  // that can never be open, and buffers up to two requests
  tcte_front #(
    .SOCKETS (SOCKETS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // engine: walks the slot table, applies the tcp rules and issues replies
  tcte_back #(
    .SOCKETS (SOCKETS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .rsp_data_o   (rsp),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready)
  );

  assign rsp_o.slot      = rsp.slot;
  assign rsp_o.flags_out = rsp.flags_out;
  assign rsp_o.seq_out   = rsp.seq_out;
  assign rsp_o.ack_out   = rsp.ack_out;
  assign rsp_o.peer_addr = rsp.peer_addr;
  assign rsp_o.peer_port = rsp.peer_port;
  assign rsp_o.own_port  = rsp.own_port;
  assign rsp_o.is_resend = rsp.is_resend;
  assign rsp_o.closing   = rsp.closing;
  assign rsp_o.last      = rsp.last;

endmodule

/* hw/rtl/tcte_checker.sv */
`include "tcp_connection_table_engine_defines.svh"

module tcte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_slot_i,
  input logic [7:0] rsp_flags_i,
  input logic       rsp_resend_i,
  input logic       rsp_closing_i
);

  `TCTE_ASSERT_CLK(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
  `TCTE_ASSERT_CLK(a_resend_slot, rsp_valid_i && rsp_resend_i |-> rsp_slot_i != 3'd0)
  `TCTE_ASSERT_CLK(a_close_slot, rsp_valid_i && rsp_closing_i |-> rsp_slot_i != 3'd0)
  `TCTE_ASSERT_ALWAYS(a_slot0_flags, rsp_valid_i && rsp_slot_i == 3'd0 |-> rsp_flags_i == tcte_pkg::FL_RST || rsp_flags_i == tcte_pkg::FL_ACK)

endmodule

bind tcp_connection_table_engine tcte_checker u_tcte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_slot_i    (rsp_o.slot),
  .rsp_flags_i   (rsp_o.flags_out),
  .rsp_resend_i  (rsp_o.is_resend),
  .rsp_closing_i (rsp_o.closing)
);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tcte_pkg::*;

  localparam int NSLOT   = SOCKETS_DEF;
  // quiet time after the last reply, with margin for a segment or tick table walk
  localparam int DRAIN   = 4 * NSLOT + 8;
  // cycles without any accepted request, reply or register access
  localparam int WD_LIMIT = 4000;
  localparam int HOLD_LEN = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  tcte_req_if req_if ();
  tcte_rsp_if rsp_if ();

  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  tcp_connection_table_engine i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the connection table and the registers
  cfg_t   cfg;
  rec_t   tbl [NSLOT];
  logic   slot_open [NSLOT];
  rsp_t   reply_step_q[$];   // replies of the request being predicted
  rsp_t   pending_q[$];      // replies still owed by the engine

  int  fail_cnt;
  int  report_cnt;
  bit  idle_en;
  bit  hold_ask;
  int  wd_cnt;

  function automatic rsp_t slot_reply(int s, logic rs, logic cl);
    rsp_t r;
    r.slot      = s[2:0];
    r.flags_out = tbl[s].send_flags;
    r.seq_out   = tbl[s].seq;
    r.ack_out   = tbl[s].ack;
    r.peer_addr = tbl[s].remote_addr;
    r.peer_port = tbl[s].remote_port;
    r.own_port  = tbl[s].local_port;
    r.is_resend = rs;
    r.closing   = cl;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic rsp_t mk_reply(logic [2:0] sl, logic [7:0] fl, logic [31:0] sq,
                                    logic [31:0] ak, logic [31:0] a, logic [15:0] pp,
                                    logic [15:0] op);
    rsp_t r;
    r = '{slot: sl, flags_out: fl, seq_out: sq, ack_out: ak, peer_addr: a, peer_port: pp,
          own_port: op, is_resend: 1'b0, closing: 1'b0, last: 1'b1};
    return r;
  endfunction

  // resend timer starts only for flags that consume sequence space or carry data
  function automatic void arm_resend(int s, logic [10:0] len);
    if ((tbl[s].send_flags & (FL_PSH | FL_SYN | FL_FIN)) != 8'h00) begin
      tbl[s].since_sent = 16'd1;
      tbl[s].retries    = 8'd0;
      if (len == 11'd0) tbl[s].next_seq = tbl[s].seq + 32'd1;
      else tbl[s].next_seq = tbl[s].next_seq + 32'(len);
    end
  endfunction

  function automatic void predict_segment(item_t it);
    int   hit;
    int   fr;
    rsp_t r;
    hit = 0;
    fr  = 0;
    for (int i = 1; i < NSLOT; i++) begin
      if (hit == 0 && slot_open[i] && tbl[i].local_port == it.local_port &&
          tbl[i].remote_port == it.remote_port && tbl[i].remote_addr == it.remote_addr)
        hit = i;
    end
    // incoming SYN with the server enabled: open the first free slot, or answer with a stateless reset
    if (cfg.server_enabled && (it.flags_in & FL_SYN) != 8'h00) begin
      if (it.syn_accepted) begin
        for (int i = 1; i < NSLOT; i++)
          if (fr == 0 && !slot_open[i]) fr = i;
      end
      if (fr != 0) begin
        tbl[fr].local_port  = it.local_port;
        tbl[fr].remote_port = it.remote_port;
        tbl[fr].remote_addr = it.remote_addr;
        tbl[fr].ack         = it.seq_in + 32'd1;
        tbl[fr].seq         = cfg.initial_seq;
        slot_open[fr]       = 1'b1;
        tbl[fr].idle        = 16'd0;
        tbl[fr].send_flags  = FL_SYN | FL_ACK;
        reply_step_q.push_back(slot_reply(fr, 1'b0, 1'b0));
        tbl[fr].seq         = cfg.initial_seq + 32'd1;
        tbl[fr].next_seq    = cfg.initial_seq + 32'd1;
        tbl[fr].since_sent  = 16'd1;
        tbl[fr].retries     = 8'd0;
        return;
      end
      hit = 0;
    end
    // no connection: stateless reset on slot 0
    if (hit == 0) begin
      r = mk_reply(3'd0, FL_RST, ((it.flags_in & FL_ACK) != 8'h00) ? it.ack_in : 32'd0,
                   32'd0, it.remote_addr, it.remote_port, it.local_port);
      reply_step_q.push_back(r);
      return;
    end
    if ((it.flags_in & FL_RST) != 8'h00) begin
      tbl[hit].send_flags = FL_RST | FL_ACK;
      slot_open[hit] = 1'b0;
      reply_step_q.push_back(slot_reply(hit, 1'b0, 1'b1));
      return;
    end
    // only an exact ACK of next_seq counts
    if ((it.flags_in & FL_ACK) != 8'h00 && it.ack_in == tbl[hit].next_seq) begin
      tbl[hit].idle       = 16'd0;
      tbl[hit].since_sent = 16'd0;
      tbl[hit].seq        = tbl[hit].next_seq;
    end
    if ((it.flags_in & FL_FIN) != 8'h00) begin
      tbl[hit].ack        = tbl[hit].ack + 32'd1;
      tbl[hit].send_flags = FL_ACK | FL_FIN;
      slot_open[hit]      = 1'b0;
      reply_step_q.push_back(slot_reply(hit, 1'b0, 1'b1));
      arm_resend(hit, 11'd0);
      return;
    end
    // in-order data only; out-of-order is dropped silently
    if (it.payload_len != 11'd0 && tbl[hit].ack == it.seq_in) begin
      tbl[hit].ack = it.seq_in + 32'(it.payload_len);
      if (it.ack_now) begin
        if (tbl[hit].since_sent != 16'd0) begin
          // stored frame still unacknowledged: bare ACK on slot 0 keeps it
          r = mk_reply(3'd0, FL_ACK, tbl[hit].next_seq, tbl[hit].ack, it.remote_addr,
                       it.remote_port, it.local_port);
          r.last = 1'b0;
          reply_step_q.push_back(r);
        end else begin
          tbl[hit].send_flags = FL_ACK;
          reply_step_q.push_back(slot_reply(hit, 1'b0, 1'b0));
        end
      end
    end
  endfunction

  function automatic void predict_tick();
    int     n;
    logic   cl;
    logic [7:0] old;
    n = 0;
    for (int i = 1; i < NSLOT; i++) begin
      if (slot_open[i]) begin
        if (tbl[i].idle != CNT16_MAX) tbl[i].idle = tbl[i].idle + 16'd1;
        if (tbl[i].since_sent != 16'd0) begin
          if (tbl[i].since_sent != CNT16_MAX) tbl[i].since_sent = tbl[i].since_sent + 16'd1;
          // at most MAX_RES retransmits per tick, the rest wait for a later tick
          if (tbl[i].since_sent > cfg.resend_ticks && n < MAX_RES) begin
            old = tbl[i].retries;
            cl  = 1'b0;
            tbl[i].since_sent = 16'd1;
            if (tbl[i].retries != CNT8_MAX) tbl[i].retries = tbl[i].retries + 8'd1;
            if (old > cfg.max_retries) begin
              slot_open[i] = 1'b0;
              cl = 1'b1;
            end
            reply_step_q.push_back(slot_reply(i, 1'b1, cl));
            n++;
          end
        end
      end
    end
  endfunction

  function automatic void predict_request(item_t it);
    int s;
    reply_step_q.delete();
    s = int'(it.slot_sel);
    case (it.op)
      REQ_SEG:  predict_segment(it);
      REQ_TICK: predict_tick();
      default: begin
        if (s >= 1 && s < NSLOT && slot_open[s]) begin
          if (it.op == REQ_SEND) begin
            tbl[s].send_flags = it.flags_in;
            reply_step_q.push_back(slot_reply(s, 1'b0, 1'b0));
            arm_resend(s, it.payload_len);
          end else begin
            tbl[s].send_flags = FL_FIN;
            tbl[s].since_sent = 16'd0;
            reply_step_q.push_back(slot_reply(s, 1'b0, 1'b0));
            arm_resend(s, 11'd0);
          end
        end
      end
    endcase
    if (reply_step_q.size() > 0) reply_step_q[reply_step_q.size()-1].last = 1'b1;
  endfunction

  function automatic item_t mk(req_type_e op, logic [31:0] a, logic [15:0] rp,
                               logic [15:0] lp, logic [31:0] sq, logic [31:0] ak,
                               logic [7:0] fl, logic [10:0] len, logic acc, logic now,
                               logic [2:0] sel);
    item_t it;
    it = '{op: op, remote_addr: a, remote_port: rp, local_port: lp, seq_in: sq, ack_in: ak,
           flags_in: fl, payload_len: len, syn_accepted: acc, ack_now: now, slot_sel: sel};
    return it;
  endfunction

  // random request, mostly well-formed traffic on live connections
  function automatic item_t gen_request();
    item_t it;
    int    k;
    int    s;
    k = $urandom_range(0, 99);
    it = mk(req_type_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 11'($urandom_range(0, 1500)), $urandom, $urandom, $urandom);
    s = 0;
    for (int t = 0; t < 8 && s == 0; t++) begin
      k = k;
      if (slot_open[$urandom_range(1, NSLOT-1)]) s = -1;
    end
    if (s == -1) begin
      s = $urandom_range(1, NSLOT-1);
      while (!slot_open[s]) s = (s % (NSLOT-1)) + 1;
    end
    if (k < 15) begin
      it.op = REQ_SEG;
      it.flags_in = ($urandom_range(0, 3) == 0) ? (FL_SYN | FL_ACK) : FL_SYN;
      it.syn_accepted = (k < 13);
      it.local_port = 16'(80 + $urandom_range(0, 2));
    end else if (k < 50 && s > 0) begin
      it.op          = REQ_SEG;
      it.remote_addr = tbl[s].remote_addr;
      it.remote_port = tbl[s].remote_port;
      it.local_port  = tbl[s].local_port;
      it.seq_in      = ($urandom_range(0, 4) == 0) ? $urandom : tbl[s].ack;
      it.ack_in      = ($urandom_range(0, 3) == 0) ? $urandom : tbl[s].next_seq;
      it.flags_in    = ($urandom_range(0, 1) == 0) ? FL_ACK : (FL_ACK | FL_PSH);
      if ($urandom_range(0, 9) == 0) it.flags_in = it.flags_in | FL_FIN;
      if ($urandom_range(0, 14) == 0) it.flags_in = it.flags_in | FL_RST;
      it.payload_len = ($urandom_range(0, 3) == 0) ? 11'd0 : 11'($urandom_range(1, 200));
    end else if (k < 68) begin
      it.op = REQ_TICK;
    end else if (k < 88) begin
      it.op = ($urandom_range(0, 3) == 0) ? REQ_CLOSE : REQ_SEND;
      if (s > 0 && $urandom_range(0, 3) != 0) it.slot_sel = 3'(s);
      case ($urandom_range(0, 4))
        0: it.flags_in = FL_PSH | FL_ACK;
        1: it.flags_in = FL_ACK;
        2: it.flags_in = FL_SYN;
        3: it.flags_in = FL_FIN | FL_ACK;
        default: it.flags_in = $urandom;
      endcase
    end
    return it;
  endfunction

  // hand one request to the engine; predict at the accepting edge
  task automatic offer(item_t it, bit typed, rsp_t typed_reply);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= it.op;
    req_if.remote_addr  <= it.remote_addr;
    req_if.remote_port  <= it.remote_port;
    req_if.local_port   <= it.local_port;
    req_if.seq_in       <= it.seq_in;
    req_if.ack_in       <= it.ack_in;
    req_if.flags_in     <= it.flags_in;
    req_if.payload_len  <= it.payload_len;
    req_if.syn_accepted <= it.syn_accepted;
    req_if.ack_now      <= it.ack_now;
    req_if.slot_sel     <= it.slot_sel;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(it);
    if (typed) pending_q.push_back(typed_reply);
    else foreach (reply_step_q[i]) pending_q.push_back(reply_step_q[i]);
  endtask

  // stop offering and wait for every reply, then, if full is set, for the engine to go quiet
  task automatic drain(bit full);
    req_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    if (full) repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RESEND: cfg.resend_ticks   = val[15:0];
      REG_RETRY:  cfg.max_retries    = val[7:0];
      REG_SERVER: cfg.server_enabled = val[0];
      default:    cfg.initial_seq    = val;
    endcase
  endtask

  task automatic set_config(logic [15:0] rt, logic [7:0] mr, logic se, logic [31:0] iseq);
    drain(1'b1);
    write_reg(REG_RESEND, 32'(rt));
    write_reg(REG_RETRY, 32'(mr));
    write_reg(REG_SERVER, 32'(se));
    write_reg(REG_ISEQ, iseq);
  endtask

  task automatic random_requests(int cnt);
    rsp_t none;
    none = '0;
    repeat (cnt) offer(gen_request(), 1'b0, none);
  endtask

  // reply side: random stall bursts plus one long hold-off on request
  int gap_left;
  int hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      gap_left  = 0;
      hold_left = 0;
    end else begin
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // reply checker, oldest expectation first
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{slot: rsp_if.slot, flags_out: rsp_if.flags_out, seq_out: rsp_if.seq_out,
              ack_out: rsp_if.ack_out, peer_addr: rsp_if.peer_addr,
              peer_port: rsp_if.peer_port, own_port: rsp_if.own_port,
              is_resend: rsp_if.is_resend, closing: rsp_if.closing, last: rsp_if.last};
      if (pending_q.size() == 0) begin
        fail_cnt++;
        if (report_cnt < 10) begin
          report_cnt++;
          $display("unexpected reply: slot %0d flags %h seq %h ack %h", got.slot,
                   got.flags_out, got.seq_out, got.ack_out);
        end
      end else begin
        want = pending_q.pop_front();
        if (got.slot !== want.slot || got.flags_out !== want.flags_out ||
            got.seq_out !== want.seq_out || got.ack_out !== want.ack_out ||
            got.peer_addr !== want.peer_addr || got.peer_port !== want.peer_port ||
            got.own_port !== want.own_port || got.is_resend !== want.is_resend ||
            got.closing !== want.closing || got.last !== want.last) begin
          fail_cnt++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("reply mismatch at %0t", $realtime);
            $display("  exp slot %0d fl %h seq %h ack %h addr %h pp %h op %h rs %b cl %b ls %b",
                     want.slot, want.flags_out, want.seq_out, want.ack_out, want.peer_addr,
                     want.peer_port, want.own_port, want.is_resend, want.closing, want.last);
            $display("  got slot %0d fl %h seq %h ack %h addr %h pp %h op %h rs %b cl %b ls %b",
                     got.slot, got.flags_out, got.seq_out, got.ack_out, got.peer_addr,
                     got.peer_port, got.own_port, got.is_resend, got.closing, got.last);
          end
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable) || !rst_ni)
      wd_cnt <= 0;
    else if (wd_cnt >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else
      wd_cnt <= wd_cnt + 1;
  end

  // directed table: typed replies only where the value is obvious
  item_t dir_req   [$];
  bit    dir_typed [$];
  rsp_t  dir_reply [$];

  task automatic add_row(item_t it, bit typed, rsp_t r);
    dir_req.push_back(it);
    dir_typed.push_back(typed);
    dir_reply.push_back(r);
  endtask

  initial begin
    rsp_t none;
    none = '0;
    fail_cnt   = 0;
    report_cnt = 0;
    idle_en    = 1'b1;
    hold_ask   = 1'b0;
    wd_cnt     = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.req_type = REQ_SEG; req_if.remote_addr = '0;
    req_if.remote_port = '0; req_if.local_port = '0; req_if.seq_in = '0;
    req_if.ack_in = '0; req_if.flags_in = '0; req_if.payload_len = '0;
    req_if.syn_accepted = 1'b0; req_if.ack_now = 1'b0; req_if.slot_sel = '0;
    cfg = '{resend_ticks: RESEND_RST, max_retries: RETRY_RST, server_enabled: SERVER_RST,
            initial_seq: ISEQ_RST};
    for (int i = 0; i < NSLOT; i++) begin
      tbl[i] = '0;
      slot_open[i] = 1'b0;
    end

    // no connection, ACK set: reset carries the peer's ack number
    add_row(mk(REQ_SEG, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFFFFFF, FL_ACK,
               11'd0, 1'b0, 1'b0, 3'd0), 1'b1,
            mk_reply(3'd0, FL_RST, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
    // no connection, no ACK: seq 0
    add_row(mk(REQ_SEG, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0, 8'h00, 11'd0, 1'b0, 1'b0, 3'd0),
            1'b1, mk_reply(3'd0, FL_RST, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    // SYN refused by the application
    add_row(mk(REQ_SEG, 32'h0A000001, 16'h1234, 16'h0050, 32'h5, 32'h77, FL_SYN | FL_ACK,
               11'd0, 1'b0, 1'b0, 3'd0), 1'b1,
            mk_reply(3'd0, FL_RST, 32'h77, 32'd0, 32'h0A000001, 16'h1234, 16'h0050));
    // SYN accepted into slot 1, ack wraps around
    add_row(mk(REQ_SEG, 32'h0A000001, 16'h1234, 16'h0050, 32'hFFFFFFFF, 32'h0, FL_SYN,
               11'd0, 1'b1, 1'b0, 3'd0), 1'b1,
            mk_reply(3'd1, FL_SYN | FL_ACK, ISEQ_RST, 32'd0, 32'h0A000001, 16'h1234,
                     16'h0050));
    add_row(mk(REQ_SEND, 0, 0, 0, 0, 0, FL_PSH, 11'd10, 1'b0, 1'b0, 3'd0), 1'b0, none);
    add_row(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 8'h00, 11'd0, 1'b0, 1'b0, 3'd7), 1'b0, none);
    // handshake ACK plus full-size in-order data, immediate ACK
    add_row(mk(REQ_SEG, 32'h0A000001, 16'h1234, 16'h0050, 32'h0, 32'hAAAAAAAB,
               FL_ACK | FL_PSH, 11'd1500, 1'b0, 1'b1, 3'd0), 1'b0, none);
    add_row(mk(REQ_SEND, 0, 0, 0, 0, 0, FL_PSH | FL_ACK, 11'd100, 1'b0, 1'b0, 3'd1),
            1'b0, none);
    add_row(mk(REQ_TICK, 0, 0, 0, 0, 0, 8'h00, 11'd0, 1'b0, 1'b0, 3'd0), 1'b0, none);
    // data while the frame waits for its ACK: bare ACK on slot 0
    add_row(mk(REQ_SEG, 32'h0A000001, 16'h1234, 16'h0050, 32'd1500, 32'h0, FL_ACK,
               11'd20, 1'b0, 1'b1, 3'd0), 1'b0, none);
    // out-of-order data is dropped
    add_row(mk(REQ_SEG, 32'h0A000001, 16'h1234, 16'h0050, 32'h12345678, 32'h0, FL_ACK,
               11'd20, 1'b0, 1'b1, 3'd0), 1'b0, none);
    add_row(mk(REQ_SEG, 32'hC0A80002, 16'h1235, 16'h0050, 32'h100, 32'h0, FL_SYN,
               11'd0, 1'b1, 1'b0, 3'd0), 1'b0, none);
    add_row(mk(REQ_SEG, 32'hC0A80002, 16'h1235, 16'h0050, 32'h101, 32'h0, FL_RST,
               11'd0, 1'b0, 1'b0, 3'd0), 1'b0, none);
    add_row(mk(REQ_CLOSE, 0, 0, 0, 0, 0, 8'h00, 11'd0, 1'b0, 1'b0, 3'd1), 1'b0, none);
    add_row(mk(REQ_SEG, 32'h0A000001, 16'h1234, 16'h0050, 32'd1520, 32'h0,
               FL_FIN | FL_ACK, 11'd5, 1'b0, 1'b0, 3'd0), 1'b0, none);
    add_row(mk(REQ_SEND, 0, 0, 0, 0, 0, FL_PSH, 11'd1, 1'b0, 1'b0, 3'd5), 1'b0, none);
    add_row(mk(REQ_TICK, 0, 0, 0, 0, 0, 8'h00, 11'd0, 1'b0, 1'b0, 3'd0), 1'b0, none);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_req[i]) offer(dir_req[i], dir_typed[i], dir_reply[i]);

    // fast resend, close on the second retransmit
    set_config(16'd1, 8'd0, 1'b1, $urandom);
    random_requests(15);
    // long hold-off on the reply side while requests keep coming
    hold_ask = 1'b1;
    idle_en  = 1'b0;
    random_requests(12);
    idle_en  = 1'b1;
    drain(1'b0);
    random_requests(10);

    // server off, max retries
    set_config(16'd2, 8'd255, 1'b0, 32'h0);
    random_requests(20);

    // slowest resend, all-ones sequence start
    set_config(16'hFFFF, 8'd3, 1'b1, 32'hFFFFFFFF);
    random_requests(20);

    // tail that ends with no idling on either side
    set_config(16'd1, 8'd1, 1'b1, $urandom);
    random_requests(10);
    idle_en = 1'b0;
    random_requests(15);

    drain(1'b1);
    if (fail_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* tcp_connection_table_engine.f */
+incdir+hw/rtl
hw/rtl/tcte_pkg.sv
hw/rtl/tcte_if.sv
hw/rtl/tcte_regs.sv
hw/rtl/tcte_front.sv
hw/rtl/tcte_back.sv
hw/rtl/tcp_connection_table_engine.sv
hw/rtl/tcte_checker.sv
bench/tb.sv
